// ===== hw/rtl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants for the cell reference parser: parse phase,
// result status codes, character bounds and accumulator limits.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

	localparam int COL_W     = 16;
	localparam int ROW_W     = 24;
	localparam int COL_ACC_W = 17;
	localparam int ROW_ACC_W = 25;
	localparam int CFG_W     = 24;

	localparam logic [COL_ACC_W-1:0] COL_SAT = '1;
	localparam logic [ROW_ACC_W-1:0] ROW_SAT = '1;

	localparam logic [COL_W-1:0] MAX_COL_RST = 16'd16384;
	localparam logic [ROW_W-1:0] MAX_ROW_RST = 24'd1048576;

	localparam logic [7:0] CH_LC_A  = 8'd97;
	localparam logic [7:0] CH_LC_Z  = 8'd122;
	localparam logic [7:0] CH_UC_A  = 8'd65;
	localparam logic [7:0] CH_UC_Z  = 8'd90;
	localparam logic [7:0] CH_CASE  = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	typedef enum logic [0:0] {
		REG_MAX_COL = 1'b0,
		REG_MAX_ROW = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ALPHA = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_COL_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic                 valid;
		phase_t               phase;
		logic                 bad;
		logic [COL_ACC_W-1:0] col;
		logic [ROW_ACC_W-1:0] row;
	} crp_fin_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crp_accum.sv =====
// ----------------------------------------------------------------------------
// crp_accum
// Per-character parse state: phase, syntax flag and saturating column and
// row accumulators. Presents the finished parse of each reference in a
// stage register when its last character is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic              advance,
	input  wire logic [7:0]        ch,
	input  wire logic              has_char,
	input  wire logic              last,
	output crp_pkg::crp_fin_t      fin_s1
);
	import crp_pkg::*;

	phase_t               phase_q, phase_d;
	logic                 bad_q, bad_d;
	logic [COL_ACC_W-1:0] col_q, col_d;
	logic [ROW_ACC_W-1:0] row_q, row_d;

	logic [7:0]           up;
	logic                 is_letter;
	logic                 is_digit;
	logic [21:0]          col_sum;
	logic [28:0]          row_sum;
	logic [COL_ACC_W-1:0] col_sat;
	logic [ROW_ACC_W-1:0] row_sat;
	logic                 fin_valid_s1;
	phase_t               fin_phase_s1;
	logic                 fin_bad_s1;
	logic [COL_ACC_W-1:0] fin_col_s1;
	logic [ROW_ACC_W-1:0] fin_row_s1;

	always_comb begin
		up        = (ch >= CH_LC_A && ch <= CH_LC_Z) ? ch - CH_CASE : ch;
		is_letter = (up >= CH_UC_A) && (up <= CH_UC_Z);
		is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		col_sum   = {5'd0, col_q} * 22'd26 + {17'd0, up[4:0]};
		row_sum   = {4'd0, row_q} * 29'd10 + {25'd0, ch[3:0]};
		col_sat   = (col_sum > {5'd0, COL_SAT}) ? COL_SAT : col_sum[COL_ACC_W-1:0];
		row_sat   = (row_sum > {4'd0, ROW_SAT}) ? ROW_SAT : row_sum[ROW_ACC_W-1:0];

		phase_d = phase_q;
		bad_d   = bad_q;
		col_d   = col_q;
		row_d   = row_q;
		if (has_char) begin
			priority if (is_letter) begin
				if (phase_q == PH_DIGIT) begin
					bad_d = 1'b1;
				end else begin
					phase_d = PH_ALPHA;
					col_d   = col_sat;
				end
			end else if (is_digit) begin
				if (phase_q == PH_START) begin
					bad_d = 1'b1;
				end else begin
					phase_d = PH_DIGIT;
					row_d   = row_sat;
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			bad_q   <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (take) begin
			if (last) begin
				phase_q <= PH_START;
				bad_q   <= 1'b0;
				col_q   <= '0;
				row_q   <= '0;
			end else begin
				phase_q <= phase_d;
				bad_q   <= bad_d;
				col_q   <= col_d;
				row_q   <= row_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (advance) begin
			fin_valid_s1 <= take && last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			fin_phase_s1 <= phase_d;
			fin_bad_s1   <= bad_d;
			fin_col_s1   <= col_d;
			fin_row_s1   <= row_d;
		end
	end

	assign fin_s1 = '{valid: fin_valid_s1, phase: fin_phase_s1, bad: fin_bad_s1,
		col: fin_col_s1, row: fin_row_s1};

endmodule

`default_nettype wire

// ===== hw/rtl/cell_reference_parser.sv =====
// ----------------------------------------------------------------------------
// cell_reference_parser
// Parses A1-style spreadsheet cell references, one character per transaction,
// and returns status, row and column for each reference.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one ASCII character, s_tuser flags that the
// character is real (low means a terminator with no character), s_tlast ends
// the reference. Only the transaction with s_tlast produces a result.
// Output stream: m_tuser carries the status (ok, malformed or row out of
// range, column too large); m_tdata carries row and column, zero unless ok.
// Configuration: cfg_we writes cfg_data to max_col (index 0) or max_row
// (index 1) at the clock edge; write only while the block is idle.
// Throughput: one character per cycle while the output is not stalled,
// set by the column (times 26) and row (times 10) accumulator updates.
// Result path: a reference's result is registered in the accumulator stage
// when its last character is taken, then in the range check stage.
// Stall: while m_tvalid is high and m_tready low, the pipeline holds and
// s_tready is low; the held result stays stable.
// Reset: arst_n clears the parse state and output valid, and loads max_col
// with 16384 and max_row with 1048576.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_reference_parser (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [7:0]                s_tdata,  // [7:0] ch
	input  wire logic                      s_tuser,  // [0] has_char
	input  wire logic                      s_tlast,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [39:0]                    m_tdata,  // [23:0] row, [39:24] col
	output logic [1:0]                     m_tuser,  // [1:0] status
	input  wire logic                      cfg_we,
	input  wire logic [0:0]                cfg_index,
	input  wire logic [crp_pkg::CFG_W-1:0] cfg_data
);
	import crp_pkg::*;

	logic              advance;
	logic              take;
	crp_fin_t          fin_s1;
	logic [COL_W-1:0]  max_col_q;
	logic [ROW_W-1:0]  max_row_q;
	status_t           status_d;
	logic [ROW_W-1:0]  row_d;
	logic [COL_W-1:0]  col_d;
	logic              valid_s2;
	status_t           status_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = advance;
	assign take     = s_tvalid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_col_q <= MAX_COL_RST;
			max_row_q <= MAX_ROW_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_COL: max_col_q <= cfg_data[COL_W-1:0];
				REG_MAX_ROW: max_row_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	crp_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.advance  (advance),
		.ch       (s_tdata),
		.has_char (s_tuser),
		.last     (s_tlast),
		.fin_s1   (fin_s1)
	);

	always_comb begin
		row_d = '0;
		col_d = '0;
		priority if (fin_s1.bad || fin_s1.phase != PH_DIGIT) begin
			status_d = ST_MALFORMED;
		end else if (fin_s1.col > {1'b0, max_col_q}) begin
			status_d = ST_COL_RANGE;
		end else if (fin_s1.row == '0 || fin_s1.row > {1'b0, max_row_q}) begin
			status_d = ST_MALFORMED;
		end else begin
			status_d = ST_OK;
			row_d    = fin_s1.row[ROW_W-1:0];
			col_d    = fin_s1.col[COL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fin_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fin_s1.valid) begin
			status_s2 <= status_d;
			row_s2    <= row_d;
			col_s2    <= col_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {col_s2, row_s2};

	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK |->
			row_s2 != '0 && row_s2 <= max_row_q && col_s2 != '0 && col_s2 <= max_col_q)
		else $error("ok result outside configured range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("error result carries nonzero row or column");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_MALFORMED ||
			m_tuser == ST_COL_RANGE)
		else $error("unknown status code");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> fin_s1.valid)
		else $error("last character did not produce a pending result");

	a_no_result_without_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !fin_s1.valid)
		else $error("result produced without a last character");

endmodule

`default_nettype wire

// ===== dv/cell_reference_parser_tb.sv =====
// ----------------------------------------------------------------------------
// cell_reference_parser_tb
// Self-checking bench for the A1 cell reference parser. Streams references
// one character per transaction: a short directed set of corner cases, then
// well-formed references with random content near the column and row limits
// mixed with garbage and broken references. The run steps through several
// max_col/max_row settings, extremes and zero included. A scoreboard tracks
// parse state per character and checks status, row and column of every
// result. Random idles and a long output hold exercise backpressure.
// ----------------------------------------------------------------------------

module cell_reference_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crp_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef logic [7:0] char_q_t[$];

	typedef struct {
		status_t     status;
		logic [23:0] row;
		logic [15:0] col;
	} cell_ref_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] ch
	logic              s_tuser;   // [0] has_char
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [39:0]       m_tdata;   // [23:0] row, [39:24] col
	logic [1:0]        m_tuser;   // [1:0] status
	logic              cfg_we;
	logic [0:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	// scoreboard state
	logic [COL_W-1:0]     lim_col;
	logic [ROW_W-1:0]     lim_row;
	phase_t               parse_phase;
	logic                 parse_bad;
	logic [COL_ACC_W-1:0] acc_col;
	logic [ROW_ACC_W-1:0] acc_row;
	cell_ref_t            pending_refs[$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned n_chars;
	int unsigned n_results;
	int unsigned n_settings;
	int unsigned n_errors;

	cell_reference_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic fold_char(input logic [7:0] c);
		logic [7:0]  up;
		logic [31:0] v;
		up = c;
		if (c >= CH_LC_A && c <= CH_LC_Z)
			up = c - CH_CASE;
		if (up >= CH_UC_A && up <= CH_UC_Z) begin
			if (parse_phase == PH_DIGIT) begin
				parse_bad = 1'b1;
			end else begin
				parse_phase = PH_ALPHA;
				v = {15'd0, acc_col} * 32'd26 + {24'd0, up} - 32'd64;
				acc_col = (v > {15'd0, COL_SAT}) ? COL_SAT : v[COL_ACC_W-1:0];
			end
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			if (parse_phase == PH_START) begin
				parse_bad = 1'b1;
			end else begin
				parse_phase = PH_DIGIT;
				v = {7'd0, acc_row} * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
				acc_row = (v > {7'd0, ROW_SAT}) ? ROW_SAT : v[ROW_ACC_W-1:0];
			end
		end else begin
			parse_bad = 1'b1;
		end
	endtask

	task automatic track_char(input logic [7:0] c, input logic has, input logic fin);
		cell_ref_t res;
		if (has)
			fold_char(c);
		if (fin) begin
			res.row = '0;
			res.col = '0;
			if (parse_bad || parse_phase != PH_DIGIT) begin
				res.status = ST_MALFORMED;
			end else if (acc_col > {1'b0, lim_col}) begin
				res.status = ST_COL_RANGE;
			end else if (acc_row == '0 || acc_row > {1'b0, lim_row}) begin
				res.status = ST_MALFORMED;
			end else begin
				res.status = ST_OK;
				res.row = acc_row[ROW_W-1:0];
				res.col = acc_col[COL_W-1:0];
			end
			pending_refs.insert(pending_refs.size(), res);
			parse_phase = PH_START;
			parse_bad = 1'b0;
			acc_col = '0;
			acc_row = '0;
		end
	endtask

	always @(posedge clk) begin
		cell_ref_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (pending_refs.size() == 0) begin
					$error("unexpected result: status %0d row %0d col %0d",
						m_tuser, m_tdata[23:0], m_tdata[39:24]);
					n_errors++;
				end else begin
					got = pending_refs.pop_front();
					if (m_tuser !== got.status) begin
						$error("status: expected %0d, actual %0d", got.status, m_tuser);
						n_errors++;
					end
					if (m_tdata[23:0] !== got.row) begin
						$error("row: expected %0d, actual %0d", got.row, m_tdata[23:0]);
						n_errors++;
					end
					if (m_tdata[39:24] !== got.col) begin
						$error("col: expected %0d, actual %0d", got.col, m_tdata[39:24]);
						n_errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				track_char(s_tdata, s_tuser, s_tlast);
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Stalled for %0d cycles with %0d results outstanding",
				quiet_cycles, pending_refs.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= has;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_chars++;
	endtask

	// optionally pad with character-less transactions; end_empty closes the
	// reference with a character-less last transaction
	task automatic send_ref(input char_q_t q, input int unsigned gap_pct, input bit end_empty);
		for (int i = 0; i < q.size(); i++) begin
			if ($urandom_range(99) < gap_pct)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(q[i], 1'b1, (i == q.size() - 1) && !end_empty);
		end
		if (end_empty || q.size() == 0)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	function automatic char_q_t to_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), s[i]);
		return q;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] specials[6];
		int unsigned r;
		specials = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A};
		r = $urandom_range(9);
		if (r <= 2)
			return CH_UC_A + 8'($urandom_range(25)) + ($urandom_range(1) ? CH_CASE : 8'd0);
		else if (r <= 5)
			return CH_ZERO + 8'($urandom_range(9));
		else if (r == 6)
			return specials[$urandom_range(5)];
		return 8'($urandom_range(255));
	endfunction

	task automatic send_random_ref();
		char_q_t     q;
		char_q_t     tmp;
		int unsigned kind;
		int unsigned colv;
		int unsigned rowv;
		int unsigned hi;
		int unsigned d;
		logic [7:0]  letter;
		bit          huge_row;
		kind = $urandom_range(99);
		if (kind < 90) begin
			case ($urandom_range(9))
				0: colv = 1;
				1: colv = (lim_col == 0) ? 1 : lim_col;
				2: colv = lim_col + 1;
				3: colv = ($urandom_range(1) ? 26 : 27) + ($urandom_range(1) ? 676 : 0);
				4: colv = $urandom_range(20000000, 131000);
				5: colv = $urandom_range(65535, 1);
				default: begin
					hi = (lim_col < 2) ? 2 : ((lim_col > 20000) ? 20000 : lim_col);
					colv = $urandom_range(hi, 1);
				end
			endcase
			while (colv > 0) begin
				colv = colv - 1;
				d = colv % 26;
				colv = colv / 26;
				letter = CH_UC_A + 8'(d) + ($urandom_range(1) ? CH_CASE : 8'd0);
				q.push_front(letter);
			end
			huge_row = 1'b0;
			case ($urandom_range(9))
				0: rowv = 1;
				1: rowv = (lim_row == 0) ? 1 : lim_row;
				2: rowv = lim_row + 1;
				3: rowv = 0;
				4: huge_row = 1'b1;
				5: rowv = $urandom_range(16777215, 1);
				default: begin
					hi = (lim_row < 2) ? 2 : ((lim_row > 9999) ? 9999 : lim_row);
					rowv = $urandom_range(hi, 1);
				end
			endcase
			if (huge_row) begin
				q.insert(q.size(), CH_ZERO + 8'($urandom_range(9, 1)));
				repeat ($urandom_range(10, 7))
					q.insert(q.size(), CH_ZERO + 8'($urandom_range(9)));
			end else if (rowv == 0) begin
				repeat ($urandom_range(3, 1))
					q.insert(q.size(), CH_ZERO);
			end else begin
				while (rowv > 0) begin
					tmp.push_front(CH_ZERO + 8'(rowv % 10));
					rowv = rowv / 10;
				end
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(2, 1))
						tmp.push_front(CH_ZERO);
				q = {q, tmp};
			end
			if (kind >= 78)
				q[$urandom_range(q.size() - 1)] = noise_char();
			send_ref(q, 6, $urandom_range(9) == 0);
		end else begin
			repeat ($urandom_range(6))
				q.insert(q.size(), noise_char());
			send_ref(q, 10, (q.size() == 0) || ($urandom_range(4) == 0));
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		target = n_chars + count;
		while (n_chars < target)
			send_random_ref();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_refs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_MAX_COL)
			lim_col = val[COL_W-1:0];
		else
			lim_row = val[ROW_W-1:0];
	endtask

	task automatic set_limits(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
		drain();
		write_reg(REG_MAX_COL, {8'd0, col});
		write_reg(REG_MAX_ROW, row);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic test_directed();
		char_q_t ff;
		ff = '{8'hFF};
		tx_idle_pct = 29;
		rx_idle_pct = 84;
		send_ref(to_chars(""), 0, 1'b1);
		send_ref(to_chars("a1"), 0, 1'b0);
		send_ref(to_chars("1A"), 0, 1'b0);
		send_ref(to_chars("A1b"), 0, 1'b0);
		send_ref(to_chars("A0"), 0, 1'b0);
		send_ref(to_chars("Z"), 0, 1'b1);
		send_ref(to_chars("@1"), 0, 1'b0);
		send_ref(ff, 0, 1'b0);
		send_ref(to_chars("XFE1"), 0, 1'b0);
		send_ref(to_chars("A9"), 100, 1'b0);
	endtask

	task automatic test_default_limits();
		tx_idle_pct = 29;
		rx_idle_pct = 84;
		run_random(530);
	endtask

	task automatic test_extreme_limits();
		tx_idle_pct = 84;
		rx_idle_pct = 29;
		set_limits(16'hFFFF, 24'hFFFFFF);
		run_random(350);
		set_limits(16'd1, 24'd1);
		run_random(200);
		set_limits(16'd0, 24'd0);
		run_random(120);
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_limits(16'd702, 24'd5000);
		hold_left = 300;
		run_random(80);
	endtask

	task automatic test_random_limits();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (4) begin
			set_limits($urandom_range(1) ? 16'($urandom_range(2000, 1))
					: 16'($urandom_range(65535, 1)),
				$urandom_range(1) ? 24'($urandom_range(100000, 1))
					: 24'($urandom_range(16777215, 1)));
			run_random(140);
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_MAX_COL;
		cfg_data    = '0;
		lim_col     = MAX_COL_RST;
		lim_row     = MAX_ROW_RST;
		parse_phase = PH_START;
		parse_bad   = 1'b0;
		acc_col     = '0;
		acc_row     = '0;
		tx_idle_pct = 29;
		rx_idle_pct = 84;
		hold_left   = 0;
		quiet_cycles = 0;
		n_chars     = 0;
		n_results   = 0;
		n_settings  = 1;
		n_errors    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_default_limits();
		test_extreme_limits();
		test_backpressure();
		test_random_limits();

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d characters, checked %0d references under %0d limit settings",
			n_chars, n_results, n_settings);
		$display("including zero and full-range limits, saturation and output backpressure");
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
